### src/periodic_task_due_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_TASK_DUE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_DUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PDTS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PDTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/pdts_pkg.sv
// Shared constants, request codes and types of the periodic task due scheduler.
package pdts_pkg;

  localparam int NumTasks = 16;
  localparam int IdxW     = 4;
  localparam int CountW   = 5;
  localparam int TickW    = 16;
  localparam int MsW      = 32;
  localparam int ScanMax  = (NumTasks < 16) ? NumTasks : 16;

  localparam logic [1:0] ReqTick   = 2'd0;
  localparam logic [1:0] ReqScan   = 2'd1;
  localparam logic [1:0] ReqReport = 2'd2;
  localparam logic [1:0] ReqSet    = 2'd3;

  typedef struct packed {
    logic [TickW-1:0] interval;
    logic [MsW-1:0]   limit;
    logic [TickW-1:0] tick_stamp;
    logic [MsW-1:0]   ms_stamp;
  } entry_t;

  typedef struct packed {
    logic             cfg_en;
    logic             stamp_en;
    logic [IdxW-1:0]  idx;
    logic [TickW-1:0] interval;
    logic [MsW-1:0]   limit;
    logic [TickW-1:0] tick_stamp;
    logic [MsW-1:0]   ms_stamp;
  } tbl_wr_t;

endpackage

### src/pdts_table.sv
// Task table: interval/limit memory and stamp memory with registered reads.
module pdts_table (
  input  logic                          clk_i,
  input  pdts_pkg::tbl_wr_t             wr_i,
  input  logic                          rd_en_i,
  input  logic [pdts_pkg::IdxW-1:0]     rd_idx_i,
  output pdts_pkg::entry_t              rd_entry_o
);

  logic [pdts_pkg::TickW+pdts_pkg::MsW-1:0] cfg_mem   [pdts_pkg::NumTasks];
  logic [pdts_pkg::TickW+pdts_pkg::MsW-1:0] stamp_mem [pdts_pkg::NumTasks];
  logic [pdts_pkg::TickW+pdts_pkg::MsW-1:0] cfg_rd_q;
  logic [pdts_pkg::TickW+pdts_pkg::MsW-1:0] stamp_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.cfg_en) begin
      cfg_mem[wr_i.idx] <= {wr_i.interval, wr_i.limit};
    end
    if (rd_en_i) begin
      cfg_rd_q <= cfg_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.stamp_en) begin
      stamp_mem[wr_i.idx] <= {wr_i.tick_stamp, wr_i.ms_stamp};
    end
    if (rd_en_i) begin
      stamp_rd_q <= stamp_mem[rd_idx_i];
    end
  end

  assign rd_entry_o = {cfg_rd_q, stamp_rd_q};

endmodule

### src/pdts_eval.sv
// Due check of one task entry against the tick counter and the current time.
module pdts_eval (
  input  pdts_pkg::entry_t             entry_i,
  input  logic [pdts_pkg::TickW-1:0]   tick_i,
  input  logic [pdts_pkg::MsW-1:0]     now_i,
  output logic                         due_o
);

  logic [pdts_pkg::TickW-1:0] dt_tick;
  logic [pdts_pkg::MsW-1:0]   dt_ms;

  assign dt_tick = tick_i - entry_i.tick_stamp;
  assign dt_ms   = now_i - entry_i.ms_stamp;
  assign due_o   = (dt_tick >= entry_i.interval) || (dt_ms >= entry_i.limit);

endmodule

### src/periodic_task_due_scheduler.sv
// Top level of the periodic task due scheduler.
// Tick, set and report beats give no result.
// A scan reads one table entry per cycle unless the output stalls; each result passes the table
// read register and the output register, and the input stays stalled until the last result leaves.
// Output stalls pause the entry reads; the rate is set by the single table read port.
// Reset clears the tick counter, task_count and the control state; table entries need no clearing.
module periodic_task_due_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic [pdts_pkg::IdxW-1:0]       task_index_i,
  input  logic [pdts_pkg::TickW-1:0]      interval_ticks_i,
  input  logic [pdts_pkg::MsW-1:0]        limit_ms_i,
  input  logic [pdts_pkg::MsW-1:0]        now_ms_i,
  input  logic                            run_ok_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pdts_pkg::IdxW-1:0]       out_task_o,
  output logic                            due_o,
  output logic                            entry_valid_o,
  output logic                            last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  `include "periodic_task_due_scheduler_assert.svh"

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                          state_q, state_d;
  logic [pdts_pkg::CountW-1:0]   task_count_q, task_count_d;
  logic [pdts_pkg::TickW-1:0]    tick_q, tick_d;
  logic [pdts_pkg::MsW-1:0]      now_q, now_d;
  logic [pdts_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [pdts_pkg::IdxW-1:0]     last_idx_q, last_idx_d;
  logic                          empty_q, empty_d;
  logic                          out_valid_q, out_valid_d;
  logic [pdts_pkg::IdxW-1:0]     out_task_q;
  logic                          due_q, entry_valid_q, last_q;

  logic                          in_acc, scan_acc, cfg_wr, slot_free, emit;
  logic                          res_last, eval_due;
  logic [pdts_pkg::CountW-1:0]   active;
  logic                          rd_en;
  logic [pdts_pkg::IdxW-1:0]     rd_idx;
  pdts_pkg::tbl_wr_t             tbl_wr;
  pdts_pkg::entry_t              rd_entry;

  assign in_stall_o = (state_q == StScan);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign scan_acc   = in_acc && (req_type_i == pdts_pkg::ReqScan);
  assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? {{(32-pdts_pkg::CountW){1'b0}}, task_count_q} : '0;

  assign active = (task_count_q > pdts_pkg::CountW'(pdts_pkg::ScanMax))
                  ? pdts_pkg::CountW'(pdts_pkg::ScanMax) : task_count_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == StScan) && slot_free;
  assign res_last  = empty_q || (idx_q == last_idx_q);

  assign rd_en  = scan_acc || (emit && !res_last);
  assign rd_idx = scan_acc ? '0 : idx_q + 1'b1;

  always_comb begin
    tbl_wr            = '0;
    tbl_wr.idx        = task_index_i;
    tbl_wr.interval   = interval_ticks_i;
    tbl_wr.limit      = limit_ms_i;
    if (in_acc && ({1'b0, task_index_i} < pdts_pkg::CountW'(pdts_pkg::NumTasks))) begin
      case (req_type_i)
        pdts_pkg::ReqSet: begin
          tbl_wr.cfg_en   = 1'b1;
          tbl_wr.stamp_en = 1'b1;
        end
        pdts_pkg::ReqReport: begin
          tbl_wr.stamp_en   = run_ok_i;
          tbl_wr.tick_stamp = tick_q;
          tbl_wr.ms_stamp   = now_ms_i;
        end
        default: begin
        end
      endcase
    end
  end

  pdts_table u_table (
    .clk_i      (clk_i),
    .wr_i       (tbl_wr),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry)
  );

  pdts_eval u_eval (
    .entry_i (rd_entry),
    .tick_i  (tick_q),
    .now_i   (now_q),
    .due_o   (eval_due)
  );

  always_comb begin
    state_d      = state_q;
    task_count_d = cfg_wr ? pwdata[pdts_pkg::CountW-1:0] : task_count_q;
    tick_d       = tick_q;
    now_d        = now_q;
    idx_d        = idx_q;
    last_idx_d   = last_idx_q;
    empty_d      = empty_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (in_acc && (req_type_i == pdts_pkg::ReqTick)) begin
      tick_d = tick_q + 1'b1;
    end
    if (scan_acc) begin
      state_d    = StScan;
      now_d      = now_ms_i;
      idx_d      = '0;
      empty_d    = (active == '0);
      last_idx_d = pdts_pkg::IdxW'(active - 1'b1);
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (res_last) begin
        state_d = StIdle;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      task_count_q <= '0;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      last_idx_q   <= '0;
      empty_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      task_count_q <= task_count_d;
      tick_q       <= tick_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      last_idx_q   <= last_idx_d;
      empty_q      <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (emit) begin
      out_task_q    <= empty_q ? '0 : idx_q;
      due_q         <= !empty_q && eval_due;
      entry_valid_q <= !empty_q;
      last_q        <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_task_o    = out_task_q;
  assign due_o         = due_q;
  assign entry_valid_o = entry_valid_q;
  assign last_o        = last_q;

  `PDTS_ASSERT_NEXT(a_scan_enters, clk_i, rst_ni, scan_acc, state_q == StScan, "scan beat did not start a scan")
  `PDTS_ASSERT_NOW(a_idx_bound, clk_i, rst_ni, (state_q == StScan) && !empty_q, idx_q <= last_idx_q, "scan index passed the last active task")
  `PDTS_ASSERT_NOW(a_empty_result, clk_i, rst_ni, out_valid_o && !entry_valid_o, !due_o && last_o && (out_task_o == '0), "empty scan result is malformed")
  `PDTS_ASSERT_NEXT(a_tick_step, clk_i, rst_ni, in_acc && (req_type_i == pdts_pkg::ReqTick), tick_q == $past(tick_q) + 16'd1, "tick beat did not advance the counter")

endmodule
